>>> rtl/hsfd_pkg.sv
// Shared constants, types and the CRC-8 byte update for the sensor frame decoder.
package hsfd_pkg;

    localparam logic [7:0]  CRC_POLY          = 8'h31;
    localparam logic [7:0]  CRC_INIT          = 8'hFF;
    localparam logic [2:0]  POS_LAST          = 3'd5;
    localparam logic [15:0] TEMP_SPAN_CENTI   = 16'd17500;
    localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;
    localparam logic [15:0] HUM_SPAN_CENTI    = 16'd10000;

    // byte positions within a reply
    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI  = 3'd3;
    localparam logic [2:0] POS_HUM_LO  = 3'd4;

    typedef struct packed {
        logic        last;      // this beat closes a reply
        logic        ok;        // both checks passed
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } frame_info_t;

    // MSB-first CRC-8 over one byte, eight unrolled shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/hsfd_frame.sv
// Reply tracker: byte position, running CRC and the captured raw words.
module hsfd_frame
    import hsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output frame_info_t info
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        first_ok_reg, first_ok_next;

    logic [2:0] pos;
    logic [7:0] crc_base;
    logic [7:0] crc_upd;

    always_comb
    begin
        // resync or out-of-range position restarts at byte 0
        if (frame_start || pos_reg > POS_LAST)
        begin
            pos      = POS_TEMP_HI;
            crc_base = CRC_INIT;
        end
        else
        begin
            pos      = pos_reg;
            crc_base = crc_reg;
        end
        crc_upd = crc8_byte(crc_base, data_byte);

        pos_next      = pos + 3'd1;
        crc_next      = crc_upd;
        temp_next     = temp_reg;
        hum_next      = hum_reg;
        first_ok_next = first_ok_reg;

        case (pos)
            POS_TEMP_HI: temp_next = {data_byte, temp_reg[7:0]};
            POS_TEMP_LO: temp_next = {temp_reg[15:8], data_byte};
            POS_TEMP_CRC:
            begin
                first_ok_next = (data_byte == crc_base);
                crc_next      = CRC_INIT;
            end
            POS_HUM_HI:  hum_next = {data_byte, hum_reg[7:0]};
            POS_HUM_LO:  hum_next = {hum_reg[15:8], data_byte};
            default:
            begin
                pos_next = POS_TEMP_HI;
                crc_next = CRC_INIT;
            end
        endcase

        info.last     = (pos == POS_LAST);
        info.ok       = first_ok_reg && (data_byte == crc_base);
        info.temp_raw = temp_reg;
        info.hum_raw  = hum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_TEMP_HI;
            crc_reg      <= CRC_INIT;
            temp_reg     <= '0;
            hum_reg      <= '0;
            first_ok_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_reg     <= temp_next;
            hum_reg      <= hum_next;
            first_ok_reg <= first_ok_next;
        end
    end

endmodule

>>> rtl/hsfd_scale.sv
// Raw word to centi-units scaling; divide by 65535 via shift-add correction.
module hsfd_scale
    import hsfd_pkg::*;
(
    input  logic [15:0]        temp_raw,
    input  logic [15:0]        hum_raw,
    output logic signed [14:0] temp_centi,
    output logic [13:0]        hum_centi
);

    logic [31:0] t_prod, h_prod;
    logic [31:0] t_sum, h_sum;
    logic [15:0] t_quot, h_quot;
    logic [15:0] t_diff;

    // q < 65536 here, so floor(x/65535) == (x + (x>>16) + 1) >> 16
    always_comb
    begin
        t_prod = 32'(temp_raw) * 32'(TEMP_SPAN_CENTI);
        h_prod = 32'(hum_raw) * 32'(HUM_SPAN_CENTI);
        t_sum  = t_prod + {16'd0, t_prod[31:16]} + 32'd1;
        h_sum  = h_prod + {16'd0, h_prod[31:16]} + 32'd1;
        t_quot = t_sum[31:16];
        h_quot = h_sum[31:16];
        t_diff = t_quot - TEMP_OFFSET_CENTI;
        temp_centi = t_diff[14:0];
        hum_centi  = h_quot[13:0];
    end

endmodule

>>> rtl/humidity_sensor_frame_decode.sv
// Top level of the six-byte temperature/humidity reply decoder.
// Path: the beat holding byte 5 passes the input register, then loads the result register.
// Throughput: one byte beat per cycle unless held; input register -> CRC/scale -> result register.
// Byte beats keep flowing while a result waits; only a byte 5 beat waits for a full stalled output.
// Reset (rst_n low, async): both registers empty, position 0, CRC 0xFF, raw words and flag cleared.
module humidity_sensor_frame_decode
    import hsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic               frame_valid
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;

    // result register
    logic               out_valid_reg;
    logic signed [14:0] temp_out_reg;
    logic [13:0]        hum_out_reg;
    logic               ok_out_reg;

    frame_info_t        info;
    logic signed [14:0] temp_scaled;
    logic [13:0]        hum_scaled;
    logic               out_blocked;
    logic               s1_fire;
    logic               load_result;

    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .data_byte   (s1_byte_reg),
        .frame_start (s1_start_reg),
        .info        (info)
    );

    hsfd_scale u_scale (
        .temp_raw   (info.temp_raw),
        .hum_raw    (info.hum_raw),
        .temp_centi (temp_scaled),
        .hum_centi  (hum_scaled)
    );

    // held result still pending downstream
    assign out_blocked = out_valid_reg && out_stall;
    // only the closing byte needs room in the result register
    assign s1_fire     = s1_valid_reg && !(info.last && out_blocked);
    assign load_result = s1_fire && info.last;
    assign in_stall    = s1_valid_reg && !s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_result)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // failed check zeroes both values
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            temp_out_reg <= info.ok ? temp_scaled : '0;
            hum_out_reg  <= info.ok ? hum_scaled : '0;
            ok_out_reg   <= info.ok;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_out_reg;
    assign humidity_centi    = hum_out_reg;
    assign frame_valid       = ok_out_reg;

endmodule

>>> rtl/hsfd_checker.sv
// Port-level checker for the frame decoder and its bind.
module hsfd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [14:0] temperature_centi,
    input logic [13:0]        humidity_centi,
    input logic               frame_valid
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature_centi)
            && $stable(humidity_centi) && $stable(frame_valid))
        else $error("result changed while stalled");

    // failed frame reports zero values
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)
        else $error("failed frame with nonzero values");

    // good frame values in physical range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> humidity_centi <= 14'd10000
            && temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
        else $error("decoded value out of range");

    // a new result needs an accepted byte beat ahead of it through the input register
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a preceding byte beat");

endmodule

bind humidity_sensor_frame_decode hsfd_checker u_hsfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .frame_valid       (frame_valid)
);
